FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

FILE: hw/rtl/cst_pkg.sv
// Types, constants and micro-op decode for the cardinal spline tangent unit.
`default_nettype none

package cst_pkg;

  // Field widths
  localparam int COORD_W    = 24;
  localparam int T_W        = 17;
  localparam int S_W        = 16;
  localparam int OUT_W      = 32;
  localparam int HALF_W     = OUT_W / 2;
  localparam int NUM_AXES   = 3;
  localparam int WIN_DEPTH  = 4;
  localparam int IDX_W      = 2;
  localparam int AX_W       = 2;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 4 * OUT_W;

  // Shared multiplier-accumulator
  localparam int COEF_W       = 20;
  localparam int MUL_A_W      = 40;
  localparam int MUL_B_W      = 25;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int ACC_W        = 66;
  localparam int WGT_W        = MUL_A_W;
  localparam int WGT_FRAC_SH  = 22;
  localparam int TAN_FRAC_SH  = 24;
  localparam int T_Q32_SH     = 16;
  localparam int C_Q32_SH     = 32;

  localparam logic signed [COEF_W-1:0] SIX_Q14   = 20'sd98304;
  localparam logic signed [ACC_W-1:0]  RND_WGT   = ACC_W'(1) <<< (WGT_FRAC_SH - 1);
  localparam logic signed [ACC_W-1:0]  RND_TAN   = ACC_W'(1) <<< (TAN_FRAC_SH - 1);

  // Micro-op program: 4 Horner inner steps, 4 Horner outer steps,
  // 12 weighted sums, 6 half-squares
  localparam int STEP_W  = 5;
  localparam int OP_V0   = 0;
  localparam int OP_W0   = 4;
  localparam int OP_AX0  = 8;
  localparam int OP_SQ0  = 20;
  localparam int NUM_OPS = 26;

  // Square root
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = 34;
  localparam int ROOT_ITERS = 32;
  localparam int RCNT_W     = 5;

  typedef enum logic [1:0] {A_COEF, A_WGT, A_TAN} a_sel_e;
  typedef enum logic [1:0] {B_T, B_COORD, B_HI, B_LO} b_sel_e;
  typedef enum logic [1:0] {PRE_B16, PRE_C32R, PRE_RND24, PRE_ZERO} pre_sel_e;
  typedef enum logic [1:0] {WB_V, WB_W, WB_TAN, WB_RAD} wb_sel_e;

  typedef struct packed {
    logic             vld;
    a_sel_e           a_sel;
    b_sel_e           b_sel;
    logic [IDX_W-1:0] idx;
    logic [AX_W-1:0]  ax;
    logic             first;
    pre_sel_e         pre_sel;
    logic             shift16;
    logic             last;
    wb_sel_e          wb_sel;
  } mac_op_t;

  // Decode one step of the micro-op program
  function automatic mac_op_t mac_decode(input logic [STEP_W-1:0] op);
    mac_op_t m;
    logic [STEP_W-1:0] k;
    m = '0;
    k = '0;
    if (op < STEP_W'(OP_W0)) begin
      // v_i = a_i * t + b_i * 2^16
      m.vld     = 1'b1;
      m.a_sel   = A_COEF;
      m.b_sel   = B_T;
      m.idx     = op[IDX_W-1:0];
      m.first   = 1'b1;
      m.pre_sel = PRE_B16;
      m.last    = 1'b1;
      m.wb_sel  = WB_V;
    end else if (op < STEP_W'(OP_AX0)) begin
      // w_i = round(v_i * t + c_i * 2^32)
      k         = op - STEP_W'(OP_W0);
      m.vld     = 1'b1;
      m.a_sel   = A_WGT;
      m.b_sel   = B_T;
      m.idx     = k[IDX_W-1:0];
      m.first   = 1'b1;
      m.pre_sel = PRE_C32R;
      m.last    = 1'b1;
      m.wb_sel  = WB_W;
    end else if (op < STEP_W'(OP_SQ0)) begin
      // tangent axis sum over the window
      k         = op - STEP_W'(OP_AX0);
      m.vld     = 1'b1;
      m.a_sel   = A_WGT;
      m.b_sel   = B_COORD;
      m.idx     = k[IDX_W-1:0];
      m.ax      = k[IDX_W+AX_W-1:IDX_W];
      m.first   = (k[IDX_W-1:0] == '0);
      m.pre_sel = PRE_RND24;
      m.last    = (k[IDX_W-1:0] == IDX_W'(WIN_DEPTH - 1));
      m.wb_sel  = WB_TAN;
    end else if (op < STEP_W'(NUM_OPS)) begin
      // tan^2 as tan * hi * 2^16 + tan * lo
      k         = op - STEP_W'(OP_SQ0);
      m.vld     = 1'b1;
      m.a_sel   = A_TAN;
      m.b_sel   = k[0] ? B_LO : B_HI;
      m.ax      = k[AX_W:1];
      m.shift16 = !k[0];
      m.first   = (k == '0);
      m.pre_sel = PRE_ZERO;
      m.last    = (k == STEP_W'(2 * NUM_AXES - 1));
      m.wb_sel  = WB_RAD;
    end
    return m;
  endfunction

  // Horner coefficients in Q14: raw_i = ((a_i t + b_i 2^16) t) + c_i 2^32
  function automatic logic signed [COEF_W-1:0] coef_a(input logic [IDX_W-1:0] idx,
                                                      input logic [S_W-1:0]   s);
    logic signed [COEF_W-1:0] s1;
    logic signed [COEF_W-1:0] s3;
    logic signed [COEF_W-1:0] r;
    s1 = $signed({{(COEF_W-S_W){1'b0}}, s});
    s3 = s1 + (s1 <<< 1);
    case (idx)
      2'd0:    r = -s3;
      2'd1:    r = SIX_Q14 - s3;
      2'd2:    r = s3 - SIX_Q14;
      default: r = s3;
    endcase
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_b(input logic [IDX_W-1:0] idx,
                                                      input logic [S_W-1:0]   s);
    logic signed [COEF_W-1:0] s1;
    logic signed [COEF_W-1:0] r;
    s1 = $signed({{(COEF_W-S_W){1'b0}}, s});
    case (idx)
      2'd0:    r = s1 <<< 2;
      2'd1:    r = (s1 <<< 1) - SIX_Q14;
      2'd2:    r = SIX_Q14 - (s1 <<< 2);
      default: r = -(s1 <<< 1);
    endcase
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_c(input logic [IDX_W-1:0] idx,
                                                      input logic [S_W-1:0]   s);
    logic signed [COEF_W-1:0] s1;
    logic signed [COEF_W-1:0] r;
    s1 = $signed({{(COEF_W-S_W){1'b0}}, s});
    case (idx)
      2'd0:    r = -s1;
      2'd2:    r = s1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cardinal_spline_tangent.sv
// Cardinal spline tangent unit: control-point window, shared MAC and square root.
`default_nettype none

// Keeps the last four pushed 3D control points (Q16.8) and, on a query beat,
// returns the cardinal spline derivative at position t (Q1.16) with tension
// s (Q2.14) for x, y and z (Q24.8, saturated) plus its floored Euclidean
// length. tuser selects the beat kind: 0 pushes a point, 1 queries. A push
// leaves the input ready. A query holds the input not ready after its beat
// while it runs on the single 40x25 multiply-accumulate unit (26 micro-ops
// issued back to back, then a drain of the product register), through a
// restoring square root at one result bit per cycle, and into the output
// register. Pushes are taken while a result waits in the output register;
// a query that finishes while the previous result is still untaken waits
// in its last step until that result is taken.
module cardinal_spline_tangent
  import cst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [23:0] coord_x, [47:24] coord_y, [71:48] coord_z, [88:72] position_t,
  // [104:89] tension, [111:105] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] mode
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [31:0] tangent_x, [63:32] tangent_y, [95:64] tangent_z, [127:96] magnitude
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [RCNT_W-1:0]        rcnt_q, rcnt_d;
  mac_op_t                  iss, ctl_q, ctl_d;
  logic                     m_valid_q;
  logic [OUT_DATA_W-1:0]    m_data_q;

  logic [T_W-1:0]           t_q;
  logic [S_W-1:0]           s_q;
  logic signed [COORD_W-1:0] win_q [NUM_AXES][WIN_DEPTH];
  logic signed [WGT_W-1:0]  w_q   [WIN_DEPTH];
  logic signed [OUT_W-1:0]  tan_q [NUM_AXES];
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [RAD_W-1:0]         rad_q;
  logic [REM_W-1:0]         rem_q;
  logic [ROOT_W-1:0]        root_q;

  logic                     push_acc, query_acc, load_out, rad_wr;
  logic signed [COORD_W-1:0] in_coord [NUM_AXES];
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [ACC_W-1:0]  pre_val, prod_ext, acc_sum;
  logic signed [OUT_W-1:0]  tan_sat;
  logic                     tan_fit;
  logic [REM_W+1:0]         rem_sh, trial, rem_diff;
  logic                     root_ge;

  // Input beat decode
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign push_acc  = s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i;
  assign query_acc = s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_unpack
    assign in_coord[a] = $signed(s_axis_tdata_i[a*COORD_W +: COORD_W]);
  end

  // Micro-op issue and operand select
  always_comb begin
    iss     = mac_decode(step_q);
    iss.vld = iss.vld && (state_q == ST_MAC);
    ctl_d   = iss;
  end

  always_comb begin
    case (iss.a_sel)
      A_COEF:  op_a = MUL_A_W'(coef_a(iss.idx, s_q));
      A_WGT:   op_a = w_q[iss.idx];
      A_TAN:   op_a = MUL_A_W'(tan_q[iss.ax]);
      default: op_a = '0;
    endcase
    case (iss.b_sel)
      B_T:     op_b = $signed({{(MUL_B_W-T_W){1'b0}}, t_q});
      B_COORD: op_b = MUL_B_W'(win_q[iss.ax][iss.idx]);
      B_HI:    op_b = MUL_B_W'($signed(tan_q[iss.ax][OUT_W-1:HALF_W]));
      B_LO:    op_b = $signed({{(MUL_B_W-HALF_W){1'b0}}, tan_q[iss.ax][HALF_W-1:0]});
      default: op_b = '0;
    endcase
  end

  // Accumulate stage on the registered product
  always_comb begin
    case (ctl_q.pre_sel)
      PRE_B16:   pre_val = ACC_W'(coef_b(ctl_q.idx, s_q)) <<< T_Q32_SH;
      PRE_C32R:  pre_val = (ACC_W'(coef_c(ctl_q.idx, s_q)) <<< C_Q32_SH) + RND_WGT;
      PRE_RND24: pre_val = RND_TAN;
      default:   pre_val = '0;
    endcase
    prod_ext = ACC_W'(prod_q);
    if (ctl_q.shift16) begin
      prod_ext = prod_ext <<< HALF_W;
    end
    acc_sum = (ctl_q.first ? pre_val : acc_q) + prod_ext;
  end

  // Round-to-Q8 result saturated to 32 bits
  always_comb begin
    tan_fit = (&acc_sum[ACC_W-1:TAN_FRAC_SH+OUT_W-1]) ||
              !(|acc_sum[ACC_W-1:TAN_FRAC_SH+OUT_W-1]);
    if (tan_fit) begin
      tan_sat = acc_sum[TAN_FRAC_SH+OUT_W-1:TAN_FRAC_SH];
    end else if (acc_sum[ACC_W-1]) begin
      tan_sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      tan_sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  assign rad_wr = ctl_q.vld && ctl_q.last && (ctl_q.wb_sel == WB_RAD);

  // Restoring square root step: two radicand bits in, one root bit out
  always_comb begin
    rem_sh   = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
    trial    = {{(REM_W-ROOT_W){1'b0}}, root_q, 2'b01};
    root_ge  = (rem_sh >= trial);
    rem_diff = rem_sh - trial;
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    rcnt_d   = rcnt_q;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          state_d = ST_MAC;
          step_d  = '0;
        end
      end
      ST_MAC: begin
        if (step_q != STEP_W'(NUM_OPS)) begin
          step_d = step_q + STEP_W'(1);
        end
        if (rad_wr) begin
          state_d = ST_ROOT;
          rcnt_d  = '0;
        end
      end
      ST_ROOT: begin
        rcnt_d = rcnt_q + RCNT_W'(1);
        if (rcnt_q == RCNT_W'(ROOT_ITERS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers and the point window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      rcnt_q    <= '0;
      ctl_q     <= '0;
      m_valid_q <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          win_q[a][i] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      rcnt_q  <= rcnt_d;
      ctl_q   <= ctl_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (push_acc) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_q[a][i] <= win_q[a][i+1];
          end
          win_q[a][WIN_DEPTH-1] <= in_coord[a];
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      t_q <= s_axis_tdata_i[NUM_AXES*COORD_W +: T_W];
      s_q <= s_axis_tdata_i[NUM_AXES*COORD_W+T_W +: S_W];
    end
    prod_q <= op_a * op_b;
    if (ctl_q.vld) begin
      acc_q <= acc_sum;
      if (ctl_q.last) begin
        case (ctl_q.wb_sel)
          WB_V:    w_q[ctl_q.idx]  <= acc_sum[WGT_W-1:0];
          WB_W:    w_q[ctl_q.idx]  <= acc_sum[WGT_W+WGT_FRAC_SH-1:WGT_FRAC_SH];
          WB_TAN:  tan_q[ctl_q.ax] <= tan_sat;
          default: rad_q           <= acc_sum[RAD_W-1:0];
        endcase
      end
    end
    if (rad_wr) begin
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == ST_ROOT) begin
      rad_q  <= rad_q << 2;
      rem_q  <= root_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], root_ge};
    end
    if (load_out) begin
      m_data_q <= {root_q, tan_q[2], tan_q[1], tan_q[0]};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cst_checker.sv
// Port-level checker for the cardinal spline tangent unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module cst_checker
  import cst_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic [OUT_W:0] mag_ext;
  logic [OUT_W:0] abs_x, abs_y, abs_z;
  logic [OUT_W:0] ext_x, ext_y, ext_z;
  logic           push_beat, query_beat;

  assign push_beat  = s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i;
  assign query_beat = s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i;

  // Absolute tangent components, one bit wider so the most negative fits
  assign ext_x   = {m_axis_tdata_o[OUT_W-1], m_axis_tdata_o[OUT_W-1:0]};
  assign ext_y   = {m_axis_tdata_o[2*OUT_W-1], m_axis_tdata_o[2*OUT_W-1:OUT_W]};
  assign ext_z   = {m_axis_tdata_o[3*OUT_W-1], m_axis_tdata_o[3*OUT_W-1:2*OUT_W]};
  assign abs_x   = ext_x[OUT_W] ? ((OUT_W+1)'(0) - ext_x) : ext_x;
  assign abs_y   = ext_y[OUT_W] ? ((OUT_W+1)'(0) - ext_y) : ext_y;
  assign abs_z   = ext_z[OUT_W] ? ((OUT_W+1)'(0) - ext_z) : ext_z;
  assign mag_ext = {1'b0, m_axis_tdata_o[4*OUT_W-1:3*OUT_W]};

  // Idle with output empty while in reset
  `ASSERT_CLK_ALWAYS(a_reset_idle, !rst_ni |-> (!m_axis_tvalid_o && s_axis_tready_o), "reset state not idle")

  // Stalled result beat holds
  `ASSERT_CLK(a_out_hold, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)), "stalled result beat changed")

  // A query occupies the unit; a push does not
  `ASSERT_CLK(a_busy_after_query, query_beat |=> !s_axis_tready_o, "input ready right after a query beat")
  `ASSERT_CLK(a_ready_after_push, push_beat |=> s_axis_tready_o, "input not ready after a push beat")

  // Length is never shorter than any component
  `ASSERT_CLK(a_mag_bound, m_axis_tvalid_o |-> ((mag_ext >= abs_x) && (mag_ext >= abs_y) && (mag_ext >= abs_z)), "magnitude below a component")

endmodule

bind cardinal_spline_tangent cst_checker u_cst_checker (.*);

`default_nettype wire

FILE: dv/cardinal_spline_tangent_tb.sv
// Self-checking testbench for the cardinal spline tangent unit.
module cardinal_spline_tangent_tb
  import cst_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {MODE_PUSH = 1'b0, MODE_QUERY = 1'b1} beat_mode_e;

  // Input beat layout, lowest field first
  localparam int X_LSB = 0;
  localparam int Y_LSB = X_LSB + COORD_W;
  localparam int Z_LSB = Y_LSB + COORD_W;
  localparam int T_LSB = Z_LSB + COORD_W;
  localparam int S_LSB = T_LSB + T_W;

  localparam int RANDOM_ITEMS = 1530;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 120;

  typedef struct {
    logic signed [OUT_W-1:0] tan_x;
    logic signed [OUT_W-1:0] tan_y;
    logic signed [OUT_W-1:0] tan_z;
    logic [OUT_W-1:0]        mag;
  } tangent_t;

  // Window model plus queue of expected tangents
  class spline_tangent_scoreboard;
    logic signed [COORD_W-1:0] win_x[WIN_DEPTH];
    logic signed [COORD_W-1:0] win_y[WIN_DEPTH];
    logic signed [COORD_W-1:0] win_z[WIN_DEPTH];
    tangent_t tangent_q[$];
    int errors;

    function new();
      foreach (win_x[i]) begin
        win_x[i] = '0;
        win_y[i] = '0;
        win_z[i] = '0;
      end
      errors = 0;
    endfunction

    function int pending();
      return tangent_q.size();
    endfunction

    // Floored square root, one result bit per pass
    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v = v - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    // Weighted window sum for one axis, rounded to Q.8 and saturated
    function longint axis_tangent(logic signed [COORD_W-1:0] win[WIN_DEPTH],
                                  longint wgt[4]);
      longint acc;
      acc = 0;
      for (int i = 0; i < 4; i++) acc += wgt[i] * longint'(win[i]);
      acc = (acc + (longint'(1) <<< 23)) >>> 24;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return acc;
    endfunction

    function tangent_t predict_tangent(logic [T_W-1:0] t_in, logic [S_W-1:0] s_in);
      longint t, s, t2, t32, one32;
      longint raw[4];
      longint wgt[4];
      longint tx, ty, tz;
      longint unsigned sq;
      tangent_t r;
      t = longint'(t_in);
      s = longint'(s_in);
      one32 = longint'(1) <<< 32;
      t2 = t * t;
      t32 = t <<< 16;
      raw[0] = (4 * t32 - one32 - 3 * t2) * s;
      raw[1] = (6 * 16384 - 3 * s) * t2 + (2 * s - 6 * 16384) * t32;
      raw[2] = (3 * s - 6 * 16384) * t2 + (6 * 16384 - 4 * s) * t32 + s * one32;
      raw[3] = (3 * t2 - 2 * t32) * s;
      for (int i = 0; i < 4; i++) wgt[i] = (raw[i] + (longint'(1) <<< 21)) >>> 22;
      tx = axis_tangent(win_x, wgt);
      ty = axis_tangent(win_y, wgt);
      tz = axis_tangent(win_z, wgt);
      sq = longint'(tx * tx) + longint'(ty * ty) + longint'(tz * tz);
      r.tan_x = tx[OUT_W-1:0];
      r.tan_y = ty[OUT_W-1:0];
      r.tan_z = tz[OUT_W-1:0];
      r.mag   = OUT_W'(floor_sqrt(sq));
      return r;
    endfunction

    // Accepted input beat: shift the window or queue a tangent
    function void note_beat(beat_mode_e mode, logic [IN_DATA_W-1:0] d);
      if (mode == MODE_PUSH) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_x[i] = win_x[i+1];
          win_y[i] = win_y[i+1];
          win_z[i] = win_z[i+1];
        end
        win_x[WIN_DEPTH-1] = d[X_LSB +: COORD_W];
        win_y[WIN_DEPTH-1] = d[Y_LSB +: COORD_W];
        win_z[WIN_DEPTH-1] = d[Z_LSB +: COORD_W];
      end else begin
        tangent_q.push_back(predict_tangent(d[T_LSB +: T_W], d[S_LSB +: S_W]));
      end
    endfunction

    // Accepted output beat against the oldest expected tangent
    function void check_beat(logic [OUT_DATA_W-1:0] d);
      tangent_t e;
      logic signed [OUT_W-1:0] ax, ay, az;
      logic [OUT_W-1:0] am;
      ax = d[0*OUT_W +: OUT_W];
      ay = d[1*OUT_W +: OUT_W];
      az = d[2*OUT_W +: OUT_W];
      am = d[3*OUT_W +: OUT_W];
      if (tangent_q.size() == 0) begin
        $error("result beat with no query outstanding: %h", d);
        errors++;
        return;
      end
      e = tangent_q.pop_front();
      if (ax !== e.tan_x) begin
        $error("tangent_x mismatch: expected %0d, got %0d", e.tan_x, ax);
        errors++;
      end
      if (ay !== e.tan_y) begin
        $error("tangent_y mismatch: expected %0d, got %0d", e.tan_y, ay);
        errors++;
      end
      if (az !== e.tan_z) begin
        $error("tangent_z mismatch: expected %0d, got %0d", e.tan_z, az);
        errors++;
      end
      if (am !== e.mag) begin
        $error("magnitude mismatch: expected %0d, got %0d", e.mag, am);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  spline_tangent_scoreboard sb;
  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  cardinal_spline_tangent DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Beat monitor and no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_beat(beat_mode_e'(s_axis_tuser), s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_beat(m_axis_tdata);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("cardinal_spline_tangent verification failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!steady && $urandom_range(99) < 7) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one beat, idling first at random; valid stays high on return
  task automatic send_beat(input beat_mode_e mode, input logic [IN_DATA_W-1:0] data);
    int gap;
    if (!steady && $urandom_range(99) < 7) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Push carries random bits in the unused t and s fields
  task automatic send_push(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z);
    logic [T_W-1:0] t_noise;
    logic [S_W-1:0] s_noise;
    t_noise = T_W'($urandom);
    s_noise = S_W'($urandom);
    send_beat(MODE_PUSH, {7'd0, s_noise, t_noise, z, y, x});
  endtask

  // Query carries random bits in the unused coordinate fields
  task automatic send_query(input logic [T_W-1:0] t, input logic [S_W-1:0] s);
    logic [3*COORD_W-1:0] c_noise;
    c_noise = {COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom)};
    send_beat(MODE_QUERY, {7'd0, s, t, c_noise});
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return COORD_W'($urandom_range(0, 1023) - 512);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [T_W-1:0] rand_t();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return T_W'(65536);
    if (r < 20) return T_W'($urandom_range(65537, 131071));
    return T_W'($urandom_range(0, 65536));
  endfunction

  function automatic logic [S_W-1:0] rand_s();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return 16'hFFFF;
    if (r < 15) return S_W'(16384);
    return S_W'($urandom);
  endfunction

  initial begin
    int n;
    int pushes;
    int queries;
    bit hold_done;
    // Reset falls at time zero so the block sees an asynchronous reset edge
    rst_ni <= 1'b0;
    n = 0;
    hold_done = 1'b0;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty window, coordinate extremes, t at and above one, s extremes
    send_query(17'd32768, 16'd16384);
    send_push(24'h7FFFFF, 24'h800000, 24'h000000);
    send_query(17'd0, 16'hFFFF);
    send_push(24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    send_push(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_push(24'h800000, 24'h800000, 24'h800000);
    send_query(17'd65536, 16'hFFFF);
    send_query(17'h1FFFF, 16'hFFFF);
    send_query(17'd65537, 16'd0);
    send_query(17'd0, 16'd0);
    send_query(17'd16384, 16'd16384);
    send_push(24'h000001, 24'hFFFFFF, 24'h000100);
    send_query(17'd98304, 16'd32768);
    send_push(24'h000100, 24'h555555, 24'hAAAAAA);
    send_query(17'h1FFFF, 16'd0);
    send_query(17'd65535, 16'd1);
    send_query(17'h0AAAA, 16'h5555);
    send_query(17'h15555, 16'hAAAA);

    // Random: mostly push runs followed by queries, some loose beats
    while (n < RANDOM_ITEMS) begin
      steady = (n >= 300 && n < 500);
      if (!hold_done && n >= 800) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) send_query(T_W'($urandom), S_W'($urandom));
        else send_push(rand_coord(), rand_coord(), rand_coord());
        n++;
      end else begin
        pushes = $urandom_range(0, 4);
        queries = $urandom_range(1, 3);
        repeat (pushes) begin
          send_push(rand_coord(), rand_coord(), rand_coord());
          n++;
        end
        repeat (queries) begin
          send_query(rand_t(), rand_s());
          n++;
        end
      end
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain outstanding tangents, then watch for stray beats
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("cardinal_spline_tangent verification clean");
    end else begin
      $display("cardinal_spline_tangent verification failed");
    end
    $finish;
  end

endmodule
